// ===== src/vd_pkg.sv =====
// Shared types and constants for the varint decoder.
// No dependencies; imported by varint_decoder_unit, its checker and the testbench.
package vd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 4;

  typedef logic signed [ByteW-1:0]  hdr_t;
  typedef logic [ValueW-1:0]        value_t;
  typedef logic [CountW-1:0]        count_t;

  // Width selector carried in tuser.
  typedef enum logic {
    KIND_INT  = 1'b0,
    KIND_LONG = 1'b1
  } kind_e;

  // Header thresholds, read as signed bytes.
  localparam hdr_t HdrMinInt  = -8'sd120;
  localparam hdr_t HdrNegInt  = -8'sd124;
  localparam hdr_t HdrMinLong = -8'sd112;
  localparam hdr_t HdrNegLong = -8'sd120;

endpackage

// ===== src/varint_decoder_unit.sv =====
// Variable-length integer decoder: input register, header/payload logic, result register.
// Depends on vd_pkg.
//
// Usage:
//   Slave stream: one raw byte per beat. tdata[7:0] is the byte; tuser is the value kind
//   (0 = 32-bit, 1 = 64-bit), looked at only on header bytes.
//   Master stream: one beat per decoded integer. tdata[63:0] is the signed value (32-bit
//   values sign-extended); tuser repeats the kind taken from the header.
//   A header byte that is the value itself yields a beat at once; otherwise the beat
//   follows the last payload byte. Header and payload bytes are fed in order.
// Path: an accepted byte goes through the input register, then the result register;
//   the decode between them is combinational: one shift, signed compares and a few muxes.
// Throughput: one byte per cycle, sustained, as long as the master side takes results.
// Stall: when a result waits and m_axis_tready is low, both registers hold; the slave
//   side still takes one byte into the empty input register, then deasserts tready.
// Reset: rst_ni clears both valid flags, the byte count (awaiting a header), the
//   accumulator, the sign mark and the latched kind.
module varint_decoder_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] data_byte
  input  logic                  s_axis_tuser,  // [0] kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [63:0]           m_axis_tdata,  // [63:0] value
  output logic                  m_axis_tuser   // [0] value_kind
);
  import vd_pkg::*;

  // input register
  logic              in_valid_q;
  kind_e             in_kind_q;
  logic [ByteW-1:0]  in_byte_q;

  // decode state
  count_t            bytes_left_q, bytes_left_d;
  value_t            acc_q, acc_d;
  logic              neg_q, neg_d;
  kind_e             cur_kind_q, cur_kind_d;

  // result register
  logic              out_valid_q;
  value_t            out_value_q, out_value_d;
  kind_e             out_kind_q, out_kind_d;
  logic              emit;

  logic              advance;
  hdr_t              hdr;
  hdr_t              lim, negl, cnt8;
  logic [31:0]       low32;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance || !in_valid_q;

  always_comb begin
    hdr          = hdr_t'(in_byte_q);
    lim          = (in_kind_q == KIND_LONG) ? HdrMinLong : HdrMinInt;
    negl         = (in_kind_q == KIND_LONG) ? HdrNegLong : HdrNegInt;
    bytes_left_d = bytes_left_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    cur_kind_d   = cur_kind_q;
    out_value_d  = out_value_q;
    out_kind_d   = out_kind_q;
    emit         = 1'b0;
    cnt8         = '0;
    low32        = '0;
    if (bytes_left_q == '0) begin
      cur_kind_d = in_kind_q;
      acc_d      = '0;
      if (hdr >= lim) begin
        emit        = 1'b1;
        neg_d       = 1'b0;
        out_value_d = value_t'(signed'(hdr));
        out_kind_d  = in_kind_q;
      end else if (hdr < negl) begin
        neg_d        = 1'b1;
        cnt8         = negl - hdr;
        bytes_left_d = cnt8[CountW-1:0];
      end else begin
        neg_d        = 1'b0;
        cnt8         = lim - hdr;
        bytes_left_d = cnt8[CountW-1:0];
      end
    end else begin
      acc_d        = {acc_q[ValueW-ByteW-1:0], in_byte_q};
      bytes_left_d = bytes_left_q - count_t'(1);
      if (bytes_left_d == '0) begin
        emit       = 1'b1;
        out_kind_d = cur_kind_q;
        if (cur_kind_q == KIND_LONG) begin
          out_value_d = {acc_d[ValueW-1] | neg_q, acc_d[ValueW-2:0]};
        end else begin
          // restore the cleared sign bit, then sign-extend from bit 31
          low32       = {acc_d[31] | neg_q, acc_d[30:0]};
          out_value_d = {{32{low32[31]}}, low32};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      bytes_left_q <= '0;
      acc_q        <= '0;
      neg_q        <= 1'b0;
      cur_kind_q   <= KIND_INT;
      out_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && emit;
        if (in_valid_q) begin
          bytes_left_q <= bytes_left_d;
          acc_q        <= acc_d;
          neg_q        <= neg_d;
          cur_kind_q   <= cur_kind_d;
        end
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q <= kind_e'(s_axis_tuser);
      in_byte_q <= s_axis_tdata;
    end
    if (advance && in_valid_q && emit) begin
      out_value_q <= out_value_d;
      out_kind_q  <= out_kind_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

// ===== src/vd_checker.sv =====
// Port-level checks for varint_decoder_unit, attached by bind.
// Depends on vd_pkg and varint_decoder_unit.
module vd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import vd_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // 32-bit results are sign-extended from bit 31
  a_int_sext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_INT) |->
      m_axis_tdata[63:32] == {32{m_axis_tdata[31]}})
    else $error("32-bit result not sign-extended");

  // with the result side free, the byte side never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no pending result");

  // a result leaves the output only through a taken beat
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result beat dropped");

endmodule

bind varint_decoder_unit vd_checker u_vd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb_varint_decoder_unit.sv =====
// Self-checking testbench for varint_decoder_unit: directed table, then random integer streams.
// Depends on vd_pkg and the DUT; predicts decoded values in-line and checks each result beat.
`timescale 1ns / 100ps

module tb_varint_decoder_unit;
  import vd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandBytes  = 1500;
  localparam int unsigned NumRows    = 25;

  typedef struct packed {
    value_t value;
    kind_e  kind;
  } varint_t;

  typedef struct packed {
    kind_e      in_kind;
    logic [7:0] data;
    logic       typed;
    value_t     exp_value;
    kind_e      exp_kind;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [63:0] value
  logic        m_axis_tuser;   // [0] value_kind

  // Predictor state
  count_t pend_cnt;
  value_t shift_acc;
  logic   neg_mark;
  kind_e  hdr_kind;

  varint_t decoded_q[$];

  int unsigned cycles         = 0;
  int unsigned errors         = 0;
  int unsigned bytes_sent;
  int unsigned values_checked = 0;
  int unsigned longs_checked  = 0;
  logic        gaps_on;
  int unsigned sink_gap;

  row_t dir_rows [0:NumRows-1] = '{
    '{KIND_INT,  8'h00, 1'b1, 64'd0,                  KIND_INT},
    '{KIND_INT,  8'h7F, 1'b1, 64'd127,                KIND_INT},
    '{KIND_INT,  8'h88, 1'b1, 64'hFFFF_FFFF_FFFF_FF88, KIND_INT},
    '{KIND_LONG, 8'h90, 1'b1, 64'hFFFF_FFFF_FFFF_FF90, KIND_LONG},
    '{KIND_INT,  8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, KIND_INT},
    // one payload byte, kind flips during payload and must be ignored
    '{KIND_INT,  8'h87, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_LONG, 8'hFF, 1'b1, 64'd255,                KIND_INT},
    // positive int whose payload has bit 31 set
    '{KIND_INT,  8'h84, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_LONG, 8'h80, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_INT,  8'h00, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_LONG, 8'h00, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_INT,  8'h01, 1'b0, 64'd0,                  KIND_INT},
    // short negative int
    '{KIND_INT,  8'h83, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_INT,  8'h80, 1'b0, 64'd0,                  KIND_INT},
    // longest negative long, sign bit already present in payload
    '{KIND_LONG, 8'h80, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_INT,  8'hFF, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_LONG, 8'hFF, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_INT,  8'hFF, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_LONG, 8'hFF, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_INT,  8'hFF, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_LONG, 8'hFF, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_INT,  8'hFF, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_LONG, 8'hFF, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_LONG, 8'h8F, 1'b0, 64'd0,                  KIND_INT},
    '{KIND_INT,  8'h00, 1'b1, 64'd0,                  KIND_LONG}
  };

  varint_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advance the predictor by one byte; returns 1 when a value completes.
  function automatic logic decode_byte(input kind_e k, input logic [7:0] b,
                                       output varint_t res);
    hdr_t   h;
    hdr_t   lim;
    hdr_t   neg;
    value_t v;
    res = '0;
    if (pend_cnt == '0) begin
      h         = hdr_t'(b);
      lim       = (k == KIND_LONG) ? HdrMinLong : HdrMinInt;
      neg       = (k == KIND_LONG) ? HdrNegLong : HdrNegInt;
      hdr_kind  = k;
      shift_acc = '0;
      if (h >= lim) begin
        neg_mark  = 1'b0;
        res.value = {{(ValueW-ByteW){h[ByteW-1]}}, h};
        res.kind  = k;
        return 1'b1;
      end
      neg_mark = (h < neg);
      pend_cnt = neg_mark ? count_t'(neg - h) : count_t'(lim - h);
      return 1'b0;
    end
    shift_acc = {shift_acc[ValueW-ByteW-1:0], b};
    pend_cnt  = pend_cnt - count_t'(1);
    if (pend_cnt != '0) return 1'b0;
    v = shift_acc;
    if (hdr_kind == KIND_LONG) begin
      if (neg_mark) v[63] = 1'b1;
    end else begin
      if (neg_mark) v[31] = 1'b1;
      v = {{32{v[31]}}, v[31:0]};
    end
    res.value = v;
    res.kind  = hdr_kind;
    return 1'b1;
  endfunction

  // Present one byte beat; enters and leaves at a falling edge.
  task automatic push_beat(input kind_e k, input logic [7:0] b,
                           input logic use_typed, input varint_t typed_v);
    varint_t pred;
    logic    hit;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    hit = decode_byte(k, b, pred);
    if (use_typed) decoded_q.push_back(typed_v);
    else if (hit) decoded_q.push_back(pred);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // One integer: mostly well-formed headers, some arbitrary header bytes.
  task automatic send_random_int();
    kind_e      k;
    int         lim;
    int         neg;
    int         n;
    int         pick;
    logic [7:0] b;
    k    = kind_e'($urandom_range(0, 1));
    lim  = (k == KIND_LONG) ? int'(HdrMinLong) : int'(HdrMinInt);
    neg  = (k == KIND_LONG) ? int'(HdrNegLong) : int'(HdrNegInt);
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      b = 8'($urandom_range(0, 255));
    end else if (pick < 5) begin
      b = 8'(lim + int'($urandom_range(0, 127 - lim)));
    end else begin
      n = $urandom_range(1, (k == KIND_LONG) ? 8 : 4);
      b = ($urandom_range(0, 1) != 0) ? 8'(neg - n) : 8'(lim - n);
    end
    push_beat(k, b, 1'b0, '0);
    while (pend_cnt != '0) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_beat(kind_e'($urandom_range(0, 1)), b, 1'b0, '0);
    end
  endtask

  // Result sink: random ready bursts while gaps are enabled.
  initial begin
    m_axis_tready = 1'b0;
    sink_gap      = 0;
    forever begin
      @(negedge clk_i);
      if (!gaps_on) sink_gap = 0;
      else if (sink_gap != 0) sink_gap--;
      else if ($urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 6);
      m_axis_tready <= (sink_gap == 0);
    end
  end

  always @(posedge clk_i) begin
    varint_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result value=%h kind=%0d", $time, m_axis_tdata,
                 m_axis_tuser);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata !== want.value) begin
          $display("%0t: value mismatch expected %h actual %h", $time, want.value,
                   m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.kind) begin
          $display("%0t: kind mismatch expected %0d actual %0d", $time, want.kind,
                   m_axis_tuser);
          errors++;
        end
        values_checked++;
        if (want.kind == KIND_LONG) longs_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d results still expected", $time, decoded_q.size());
      $display("varint_decoder_unit regression: fail");
      $finish;
    end
  end

  initial begin
    varint_t typed_v;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    gaps_on        = 1'b1;
    bytes_sent     = 0;
    pend_cnt       = '0;
    shift_acc      = '0;
    neg_mark       = 1'b0;
    hdr_kind       = KIND_INT;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      typed_v.value = dir_rows[i].exp_value;
      typed_v.kind  = dir_rows[i].exp_kind;
      push_beat(dir_rows[i].in_kind, dir_rows[i].data, dir_rows[i].typed, typed_v);
    end

    // Alternate stretches with and without gaps; keep the tail gap-free.
    while (bytes_sent < NumRows + RandBytes) begin
      gaps_on = (bytes_sent < NumRows + RandBytes - 300) &&
                (((bytes_sent / 150) % 3) != 2);
      send_random_int();
    end
    s_axis_tvalid <= 1'b0;
    gaps_on = 1'b0;

    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("sent %0d stream bytes; checked %0d decoded values, %0d of them 64-bit",
             bytes_sent, values_checked, longs_checked);
    if (errors == 0) begin
      $display("varint_decoder_unit regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("varint_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule
